// ===== rtl/usbtrs_pkg.sv =====
// Shared types and codes for the USB transfer request scheduler.
package usbtrs_pkg;

  // Operation codes
  localparam logic [2:0] OP_SUBMIT    = 3'd0;
  localparam logic [2:0] OP_CANCEL_ID = 3'd1;
  localparam logic [2:0] OP_CANCEL_EP = 3'd2;
  localparam logic [2:0] OP_COMPLETE  = 3'd3;
  localparam logic [2:0] OP_SCHEDULE  = 3'd4;
  localparam logic [2:0] OP_PURGE_ALL = 3'd5;
  localparam logic [2:0] OP_PURGE_NZ  = 3'd6;
  localparam logic [2:0] OP_FIND      = 3'd7;

  // Result kinds
  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_ABORT  = 2'd1;
  localparam logic [1:0] KIND_NOTIFY = 2'd2;
  localparam logic [1:0] KIND_RESP   = 2'd3;

  // Response codes
  localparam logic [3:0] RC_OK        = 4'd0;
  localparam logic [3:0] RC_BAD_SIZE  = 4'd1;
  localparam logic [3:0] RC_NO_SLOT   = 4'd2;
  localparam logic [3:0] RC_NOT_FOUND = 4'd3;

  // Cancel status passed to the owner
  localparam logic [3:0] ST_CANCELLED = 4'd1;

  // Transfer kind: control
  localparam logic [1:0] EPK_CONTROL = 2'd0;

  // Busy bits kept by purge of non-zero endpoints
  localparam logic [31:0] EP0_MASK = 32'h0001_0001;

  // Legal endpoint 0 control packet sizes
  localparam logic [10:0] MPS_8  = 11'd8;
  localparam logic [10:0] MPS_16 = 11'd16;
  localparam logic [10:0] MPS_32 = 11'd32;
  localparam logic [10:0] MPS_64 = 11'd64;

  // Per-slot payload held in the slot memory
  typedef struct packed {
    logic [15:0] ident;
    logic [7:0]  ep;
    logic [1:0]  nbits;   // bit 0 notify enabled, bit 1 quiet on success
  } slot_t;

endpackage

// ===== rtl/usbtrs_if.sv =====
// Handshake channel interfaces for requests, results and configuration.
interface usbtrs_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [7:0]  endpoint;
  logic [1:0]  ep_kind;
  logic [10:0] max_packet;
  logic [15:0] request_id;
  logic [3:0]  end_status;
  logic        notify_enabled;
  logic        quiet_success;
  modport source (output valid, op, endpoint, ep_kind, max_packet, request_id,
                  end_status, notify_enabled, quiet_success, input ready);
  modport sink (input valid, op, endpoint, ep_kind, max_packet, request_id,
                end_status, notify_enabled, quiet_success, output ready);
endinterface

interface usbtrs_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] req_id;
  logic [7:0]  ep_address;
  logic [3:0]  code;
  logic [3:0]  count;
  logic        last;
  modport source (output valid, kind, req_id, ep_address, code, count, last,
                  input ready);
  modport sink (input valid, kind, req_id, ep_address, code, count, last,
                output ready);
endinterface

interface usbtrs_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/usb_transfer_request_scheduler.sv =====
// USB transfer request scheduler top level: queue sequencer over the slot memory.
//
//  channel | dir | beat
//  --------+-----+-----------------------------------------------------------
//  req     | in  | op, endpoint, ep_kind, max_packet, request_id, status, opts
//  rsp     | out | kind, req_id, ep_address, code, count, last
//  cfg     | in  | force_waiting bit, always ready
//
// One request at a time. Each queue walk runs a begin state, then for each node visited
// a memory read state and a check state, then an end state. A removed node adds a notify
// state, and an abort check state when it was active and the op is no purge. A started
// node adds an append state. Submit passes through the submit and response states.
// Queues are singly linked lists in the slot memory, terminated by tail pointer.
// Synchronous reset empties both queues, frees all slots and endpoints.
// The sequencer stalls while the result register is full and not taken.
module usb_transfer_request_scheduler #(
  parameter int SLOTS = 8
) (
  input  logic         clk,
  input  logic         rst,
  usbtrs_req_if.sink   req,
  usbtrs_rsp_if.source rsp,
  usbtrs_cfg_if.sink   cfg
);
  localparam int IW = $clog2(SLOTS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SUB  = 4'd1;
  localparam logic [3:0] S_WBEG = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_ABT  = 4'd5;
  localparam logic [3:0] S_NTF  = 4'd6;
  localparam logic [3:0] S_APP  = 4'd7;
  localparam logic [3:0] S_WEND = 4'd8;
  localparam logic [3:0] S_RESP = 4'd9;

  // control state
  logic [3:0]       state, state_next;
  logic             qsel, qsel_next;          // 0 active, 1 waiting
  logic [IW-1:0]    cur, cur_next;
  logic [IW-1:0]    prv, prv_next;
  logic [IW-1:0]    nxt, nxt_next;
  logic             cont_end, cont_end_next;
  logic [IW-1:0]    act_h, act_h_next, act_t, act_t_next;
  logic             act_e, act_e_next;
  logic [IW-1:0]    wt_h, wt_h_next, wt_t, wt_t_next;
  logic             wt_e, wt_e_next;
  logic [31:0]      busy, busy_next;
  logic [15:0]      idc, idc_next;
  logic [SLOTS-1:0] free, free_next;
  logic             fw;
  logic [3:0]       ncnt, ncnt_next;

  // captured request and response fields
  logic [2:0]  op_r, op_r_next;
  logic [7:0]  ep_r, ep_r_next;
  logic [1:0]  kind_r, kind_r_next;
  logic [10:0] mps_r, mps_r_next;
  logic [15:0] rid_r, rid_r_next;
  logic [3:0]  st_r, st_r_next;
  logic [1:0]  nb_r, nb_r_next;
  logic [15:0] r_id, r_id_next;
  logic [7:0]  r_ep, r_ep_next;
  logic [3:0]  r_code, r_code_next;

  // result register
  logic        ov;
  logic        em_v;
  logic [1:0]  em_kind;
  logic [15:0] em_id;
  logic [7:0]  em_ep;
  logic [3:0]  em_code;
  logic [3:0]  em_count;
  logic        em_last;

  // memory ports
  logic              d_we, l_we, rd_en;
  logic [IW-1:0]     d_addr, l_addr, l_wdata, rd_addr;
  usbtrs_pkg::slot_t d_wdata, rd_data;
  logic [IW-1:0]     rd_link;

  // helpers
  logic          go;
  logic [IW-1:0] q_h, q_t, alloc;
  logic          q_e, is_tail, hit, sched_walk, bad_size;
  logic [4:0]    node_bit, ep_bit;
  logic [3:0]    ntf_st;

  usbtrs_slot_mem #(.SLOTS(SLOTS)) u_mem (
    .clk     (clk),
    .d_we    (d_we),
    .d_addr  (d_addr),
    .d_wdata (d_wdata),
    .l_we    (l_we),
    .l_addr  (l_addr),
    .l_wdata (l_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .rd_link (rd_link)
  );

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign go = (state != S_IDLE) && (!ov || rsp.ready);

  // lowest free slot
  always_comb begin
    alloc = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free[i]) alloc = IW'(i);
    end
  end

  assign q_h = qsel ? wt_h : act_h;
  assign q_t = qsel ? wt_t : act_t;
  assign q_e = qsel ? wt_e : act_e;
  assign is_tail = (cur == q_t);
  assign node_bit = {rd_data.ep[7], rd_data.ep[3:0]};
  assign ep_bit = {ep_r[7], ep_r[3:0]};
  assign sched_walk = (op_r == usbtrs_pkg::OP_SCHEDULE) ||
                      ((op_r == usbtrs_pkg::OP_COMPLETE) && qsel);
  assign ntf_st = ((op_r == usbtrs_pkg::OP_CANCEL_ID) || (op_r == usbtrs_pkg::OP_CANCEL_EP)) ?
                  usbtrs_pkg::ST_CANCELLED : st_r;
  assign bad_size = (kind_r == usbtrs_pkg::EPK_CONTROL) && (ep_r[3:0] == 4'd0) &&
                    !((mps_r == usbtrs_pkg::MPS_8) || (mps_r == usbtrs_pkg::MPS_16) ||
                      (mps_r == usbtrs_pkg::MPS_32) || (mps_r == usbtrs_pkg::MPS_64));

  // match rule of the current walk
  always_comb begin
    unique case (op_r)
      usbtrs_pkg::OP_CANCEL_ID: hit = (rd_data.ident == rid_r);
      usbtrs_pkg::OP_COMPLETE:  hit = qsel ? !busy[node_bit] : (rd_data.ident == rid_r);
      usbtrs_pkg::OP_CANCEL_EP: hit = (rd_data.ep == ep_r);
      usbtrs_pkg::OP_FIND:      hit = (rd_data.ep == ep_r);
      usbtrs_pkg::OP_SCHEDULE:  hit = !busy[node_bit];
      usbtrs_pkg::OP_PURGE_ALL: hit = 1'b1;
      usbtrs_pkg::OP_PURGE_NZ:  hit = (rd_data.ep[3:0] != 4'd0);
      default:                  hit = 1'b0;
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;   qsel_next = qsel;   cur_next = cur;   prv_next = prv;
    nxt_next = nxt;       cont_end_next = cont_end;
    act_h_next = act_h;   act_t_next = act_t; act_e_next = act_e;
    wt_h_next = wt_h;     wt_t_next = wt_t;   wt_e_next = wt_e;
    busy_next = busy;     idc_next = idc;     free_next = free; ncnt_next = ncnt;
    op_r_next = op_r;     ep_r_next = ep_r;   kind_r_next = kind_r; mps_r_next = mps_r;
    rid_r_next = rid_r;   st_r_next = st_r;   nb_r_next = nb_r;
    r_id_next = r_id;     r_ep_next = r_ep;   r_code_next = r_code;
    d_we = 1'b0; d_addr = alloc; d_wdata = '0;
    l_we = 1'b0; l_addr = '0;    l_wdata = '0;
    rd_en = 1'b0; rd_addr = cur;
    em_v = 1'b0; em_kind = usbtrs_pkg::KIND_RESP; em_id = '0; em_ep = '0;
    em_code = '0; em_count = '0; em_last = 1'b0;

    if (state == S_IDLE) begin
      if (req.valid) begin
        op_r_next = req.op;           ep_r_next = req.endpoint;
        kind_r_next = req.ep_kind;    mps_r_next = req.max_packet;
        rid_r_next = req.request_id;  st_r_next = req.end_status;
        nb_r_next = {req.quiet_success, req.notify_enabled};
        r_id_next = '0; r_ep_next = '0; r_code_next = usbtrs_pkg::RC_OK; ncnt_next = '0;
        qsel_next = 1'b0;
        unique case (req.op)
          usbtrs_pkg::OP_SUBMIT: state_next = S_SUB;
          usbtrs_pkg::OP_CANCEL_EP: begin
            qsel_next = !busy[{req.endpoint[7], req.endpoint[3:0]}];
            state_next = S_WBEG;
          end
          usbtrs_pkg::OP_SCHEDULE: begin
            qsel_next = 1'b1;
            state_next = fw ? S_RESP : S_WBEG;
          end
          default: state_next = S_WBEG;
        endcase
      end
    end else if (go) begin
      unique case (state)
        // allocate a slot and queue it, unless the size is bad or no slot is free
        S_SUB: begin
          state_next = S_RESP;
          r_ep_next = ep_r;
          if (bad_size) begin
            r_code_next = usbtrs_pkg::RC_BAD_SIZE;
          end else if (free == '0) begin
            r_code_next = usbtrs_pkg::RC_NO_SLOT;
          end else begin
            d_we = 1'b1;
            d_wdata = '{ident: idc, ep: ep_r, nbits: nb_r};
            free_next[alloc] = 1'b0;
            r_id_next = idc;
            idc_next = idc + 16'd1;
            if (!fw && !busy[ep_bit]) begin
              busy_next[ep_bit] = 1'b1;
              em_v = 1'b1; em_kind = usbtrs_pkg::KIND_START; em_id = idc; em_ep = ep_r;
              if (act_e) begin
                act_h_next = alloc; act_e_next = 1'b0;
              end else begin
                l_we = 1'b1; l_addr = act_t; l_wdata = alloc;
              end
              act_t_next = alloc;
            end else begin
              if (wt_e) begin
                wt_h_next = alloc; wt_e_next = 1'b0;
              end else begin
                l_we = 1'b1; l_addr = wt_t; l_wdata = alloc;
              end
              wt_t_next = alloc;
            end
          end
        end
        // start a walk of the selected queue
        S_WBEG: begin
          if (q_e) begin
            state_next = S_WEND;
          end else begin
            cur_next = q_h;
            state_next = S_RD;
          end
        end
        S_RD: begin
          rd_en = 1'b1;
          state_next = S_CHK;
        end
        // examine the node just read
        S_CHK: begin
          if (!hit) begin
            if (is_tail) begin
              state_next = S_WEND;
            end else begin
              prv_next = cur;
              cur_next = rd_link;
              state_next = S_RD;
            end
          end else if (op_r == usbtrs_pkg::OP_FIND) begin
            r_id_next = rd_data.ident; r_ep_next = ep_r;
            state_next = S_RESP;
          end else if (op_r == usbtrs_pkg::OP_PURGE_ALL) begin
            cont_end_next = is_tail; nxt_next = rd_link;
            state_next = S_NTF;
          end else begin
            // unlink the node
            if (q_h == q_t) begin
              cont_end_next = 1'b1;
              if (qsel) wt_e_next = 1'b1; else act_e_next = 1'b1;
            end else if (cur == q_h) begin
              cont_end_next = 1'b0; nxt_next = rd_link;
              if (qsel) wt_h_next = rd_link; else act_h_next = rd_link;
            end else if (is_tail) begin
              cont_end_next = 1'b1;
              if (qsel) wt_t_next = prv; else act_t_next = prv;
            end else begin
              cont_end_next = 1'b0; nxt_next = rd_link;
              l_we = 1'b1; l_addr = prv; l_wdata = rd_link;
            end
            if (sched_walk) begin
              busy_next[node_bit] = 1'b1;
              state_next = S_APP;
            end else begin
              free_next[cur] = 1'b1;
              if (op_r == usbtrs_pkg::OP_CANCEL_EP) ncnt_next = ncnt + 4'd1;
              if ((op_r == usbtrs_pkg::OP_CANCEL_ID) || (op_r == usbtrs_pkg::OP_COMPLETE)) begin
                r_id_next = rid_r; r_ep_next = rd_data.ep;
              end
              state_next = (!qsel && (op_r != usbtrs_pkg::OP_PURGE_NZ)) ? S_ABT : S_NTF;
            end
          end
        end
        // release a busy endpoint
        S_ABT: begin
          if (busy[node_bit]) begin
            busy_next[node_bit] = 1'b0;
            em_v = 1'b1; em_kind = usbtrs_pkg::KIND_ABORT;
            em_id = rd_data.ident; em_ep = rd_data.ep;
          end
          state_next = S_NTF;
        end
        // owner notification, then continue
        S_NTF: begin
          if (rd_data.nbits[0] && !(rd_data.nbits[1] && (ntf_st == 4'd0))) begin
            em_v = 1'b1; em_kind = usbtrs_pkg::KIND_NOTIFY;
            em_id = rd_data.ident; em_ep = rd_data.ep; em_code = ntf_st;
          end
          if (op_r == usbtrs_pkg::OP_CANCEL_ID) begin
            state_next = S_RESP;
          end else if (op_r == usbtrs_pkg::OP_COMPLETE) begin
            qsel_next = 1'b1;
            state_next = fw ? S_RESP : S_WBEG;
          end else if ((op_r == usbtrs_pkg::OP_CANCEL_EP) && !qsel) begin
            qsel_next = 1'b1;
            state_next = S_WBEG;
          end else if (cont_end) begin
            state_next = S_WEND;
          end else begin
            cur_next = nxt;
            state_next = S_RD;
          end
        end
        // move a started request onto the active queue
        S_APP: begin
          if (act_e) begin
            act_h_next = cur; act_e_next = 1'b0;
          end else begin
            l_we = 1'b1; l_addr = act_t; l_wdata = cur;
          end
          act_t_next = cur;
          em_v = 1'b1; em_kind = usbtrs_pkg::KIND_START;
          em_id = rd_data.ident; em_ep = rd_data.ep;
          if (cont_end) begin
            state_next = S_WEND;
          end else begin
            cur_next = nxt;
            state_next = S_RD;
          end
        end
        // end of a queue walk
        S_WEND: begin
          state_next = S_RESP;
          unique case (op_r)
            usbtrs_pkg::OP_CANCEL_ID: begin
              if (!qsel) begin
                qsel_next = 1'b1; state_next = S_WBEG;
              end else begin
                r_id_next = rid_r; r_code_next = usbtrs_pkg::RC_NOT_FOUND;
              end
            end
            usbtrs_pkg::OP_CANCEL_EP: begin
              if (!qsel) begin
                qsel_next = 1'b1; state_next = S_WBEG;
              end else begin
                r_ep_next = ep_r;
              end
            end
            usbtrs_pkg::OP_COMPLETE: begin
              if (!qsel) begin
                r_id_next = rid_r; r_code_next = usbtrs_pkg::RC_NOT_FOUND;
              end
            end
            usbtrs_pkg::OP_PURGE_ALL: begin
              if (!qsel) begin
                qsel_next = 1'b1; state_next = S_WBEG;
              end else begin
                act_e_next = 1'b1; wt_e_next = 1'b1;
                free_next = '1; busy_next = '0;
              end
            end
            usbtrs_pkg::OP_PURGE_NZ: begin
              if (!qsel) begin
                qsel_next = 1'b1; state_next = S_WBEG;
              end else begin
                busy_next = busy & usbtrs_pkg::EP0_MASK;
              end
            end
            usbtrs_pkg::OP_FIND: begin
              r_ep_next = ep_r; r_code_next = usbtrs_pkg::RC_NOT_FOUND;
            end
            default: state_next = S_RESP;
          endcase
        end
        S_RESP: begin
          em_v = 1'b1; em_kind = usbtrs_pkg::KIND_RESP; em_id = r_id; em_ep = r_ep;
          em_code = r_code; em_count = ncnt; em_last = 1'b1;
          state_next = S_IDLE;
        end
        default: state_next = S_IDLE;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      act_e <= 1'b1;
      wt_e  <= 1'b1;
      busy  <= '0;
      idc   <= '0;
      free  <= '1;
      fw    <= 1'b0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      act_e <= act_e_next;
      wt_e  <= wt_e_next;
      busy  <= busy_next;
      idc   <= idc_next;
      free  <= free_next;
      if (cfg.valid) fw <= cfg.data;
      if (em_v) ov <= 1'b1;
      else if (rsp.ready) ov <= 1'b0;
    end
  end

  // walk and payload registers
  always_ff @(posedge clk) begin
    qsel <= qsel_next;   cur <= cur_next;     prv <= prv_next;
    nxt <= nxt_next;     cont_end <= cont_end_next;
    act_h <= act_h_next; act_t <= act_t_next;
    wt_h <= wt_h_next;   wt_t <= wt_t_next;   ncnt <= ncnt_next;
    op_r <= op_r_next;   ep_r <= ep_r_next;   kind_r <= kind_r_next;
    mps_r <= mps_r_next; rid_r <= rid_r_next; st_r <= st_r_next; nb_r <= nb_r_next;
    r_id <= r_id_next;   r_ep <= r_ep_next;   r_code <= r_code_next;
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (em_v) begin
      rsp.kind <= em_kind;
      rsp.req_id <= em_id;
      rsp.ep_address <= em_ep;
      rsp.code <= em_code;
      rsp.count <= em_count;
      rsp.last <= em_last;
    end
  end

  assign rsp.valid = ov;
endmodule

// ===== rtl/usbtrs_slot_mem.sv =====
// Slot memory: payload array and link array, registered read.
module usbtrs_slot_mem #(
  parameter int SLOTS = 8
) (
  input  logic                      clk,
  input  logic                      d_we,
  input  logic [$clog2(SLOTS)-1:0]  d_addr,
  input  usbtrs_pkg::slot_t         d_wdata,
  input  logic                      l_we,
  input  logic [$clog2(SLOTS)-1:0]  l_addr,
  input  logic [$clog2(SLOTS)-1:0]  l_wdata,
  input  logic                      rd_en,
  input  logic [$clog2(SLOTS)-1:0]  rd_addr,
  output usbtrs_pkg::slot_t         rd_data,
  output logic [$clog2(SLOTS)-1:0]  rd_link
);
  localparam int IW = $clog2(SLOTS);

  usbtrs_pkg::slot_t data_mem [SLOTS];
  logic [IW-1:0]     link_mem [SLOTS];

  // payload port
  always_ff @(posedge clk) begin
    if (d_we) begin
      data_mem[d_addr] <= d_wdata;
    end
    if (rd_en) begin
      rd_data <= data_mem[rd_addr];
    end
  end

  // link port
  always_ff @(posedge clk) begin
    if (l_we) begin
      link_mem[l_addr] <= l_wdata;
    end
    if (rd_en) begin
      rd_link <= link_mem[rd_addr];
    end
  end
endmodule
